### src/eri_pkg.sv
// Shared widths, codes and types for the edge/ray intersection block.
// Depends on nothing; every other file takes names from here by scope.
package eri_pkg;

   // fixed field widths
   localparam int COORD_W   = 32;
   localparam int ROT_W     = 16;
   localparam int FRAC_W    = 31;
   localparam int CSR_IDX_W = 8;

   // default fraction bits
   localparam int DEF_COORD_FRAC_BITS = 16;
   localparam int DEF_ROT_FRAC_BITS   = 14;

   // edge length root steps
   localparam int SQRT_STEPS = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_START_X = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_START_Y = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_END_X   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_END_Y   = 8'd3;

   // edge normal sequencer
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_DIFF,
      SEQ_SCALE,
      SEQ_SQUARE,
      SEQ_ROOT,
      SEQ_DINIT,
      SEQ_DIVIDE
   } eri_seq_type;

   typedef struct packed {
      logic busy;
      logic edge_zero;
   } eri_status_type;

   typedef struct packed {
      logic valid;
      logic miss;
   } eri_ctl_type;

endpackage

### src/edge_ray_intersect_2d_top.sv
// Top level of the 2D edge/ray intersection block.
// Depends on eri_pkg, eri_edge, eri_front and eri_div.
//
//  channel  dir  handshake             word
//  req_     in   req_valid/req_ready   ray ends, max fraction, pose
//  rsp_     out  rsp_valid/rsp_ready   hit, fraction, world normal
//  csr_     in   csr_valid/csr_ready   register index, write data
//
// One item enters per cycle unless a held result or the normal sequencer
// stalls the input; each result passes 8 front stages, 31 divider stages
// and one result register. After each edge register write the normal
// sequencer runs (difference, scaling, squaring, a 32-step root, setup,
// then ROT_FRAC_BITS + 2 divide steps); req_ready stays low meanwhile.
// Reset is synchronous and empties the pipeline; the edge registers reset to zero.
// A stalled result freezes the whole pipeline; an empty first stage still
// takes a word.
module edge_ray_intersect_2d_top #(
   parameter int COORD_FRAC_BITS = eri_pkg::DEF_COORD_FRAC_BITS,
   parameter int ROT_FRAC_BITS   = eri_pkg::DEF_ROT_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_start_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_start_y,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_end_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_end_y,
   input  logic [eri_pkg::FRAC_W-1:0]         req_max_fraction,
   input  logic signed [eri_pkg::COORD_W-1:0] req_pose_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_pose_y,
   input  logic signed [eri_pkg::ROT_W-1:0]   req_pose_cos,
   input  logic signed [eri_pkg::ROT_W-1:0]   req_pose_sin,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [eri_pkg::FRAC_W-1:0]         rsp_hit_fraction,
   output logic signed [eri_pkg::ROT_W-1:0]   rsp_normal_x,
   output logic signed [eri_pkg::ROT_W-1:0]   rsp_normal_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [eri_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [eri_pkg::COORD_W-1:0]        csr_data
);
   localparam int NW   = ROT_FRAC_BITS + 3;
   localparam int NUMW = NW + (51 - ROT_FRAC_BITS) + 1;

   eri_pkg::eri_status_type status;
   eri_pkg::eri_ctl_type    f_ctl;

   logic signed [eri_pkg::COORD_W-1:0] edge_v1x, edge_v1y;
   logic signed [eri_pkg::COORD_W:0]   edge_ex, edge_ey;
   logic signed [NW-1:0]               edge_nx, edge_ny;
   logic [NUMW-1:0]                    f_unum, f_uden;
   logic signed [eri_pkg::ROT_W-1:0]   f_nx, f_ny;
   logic [eri_pkg::FRAC_W-1:0]         f_maxf;
   logic en, room, in_take;

   // advance unless a finished word is held
   assign en        = rsp_ready || !rsp_valid;
   assign req_ready = !status.busy && (en || room);
   assign in_take   = req_valid && req_ready;

   eri_edge #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_edge (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .edge_v1x  (edge_v1x),
      .edge_v1y  (edge_v1y),
      .edge_ex   (edge_ex),
      .edge_ey   (edge_ey),
      .edge_nx   (edge_nx),
      .edge_ny   (edge_ny),
      .status    (status)
   );

   eri_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .ROT_FRAC_BITS  (ROT_FRAC_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_take          (in_take),
      .room             (room),
      .req_ray_start_x  (req_ray_start_x),
      .req_ray_start_y  (req_ray_start_y),
      .req_ray_end_x    (req_ray_end_x),
      .req_ray_end_y    (req_ray_end_y),
      .req_max_fraction (req_max_fraction),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_cos     (req_pose_cos),
      .req_pose_sin     (req_pose_sin),
      .edge_v1x         (edge_v1x),
      .edge_v1y         (edge_v1y),
      .edge_ex          (edge_ex),
      .edge_ey          (edge_ey),
      .edge_nx          (edge_nx),
      .edge_ny          (edge_ny),
      .edge_zero        (status.edge_zero),
      .o_ctl            (f_ctl),
      .o_unum           (f_unum),
      .o_uden           (f_uden),
      .o_nx             (f_nx),
      .o_ny             (f_ny),
      .o_maxf           (f_maxf)
   );

   eri_div #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .ROT_FRAC_BITS  (ROT_FRAC_BITS)
   ) u_div (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .i_ctl            (f_ctl),
      .i_unum           (f_unum),
      .i_uden           (f_uden),
      .i_nx             (f_nx),
      .i_ny             (f_ny),
      .i_maxf           (f_maxf),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_hit_fraction (rsp_hit_fraction),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y)
   );

   // no word enters while the edge normal is being rebuilt
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      status.busy |-> !req_ready)
      else $error("word taken while edge normal is rebuilt");

   // a miss carries zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
      (rsp_hit_fraction == '0 && rsp_normal_x == '0 && rsp_normal_y == '0))
      else $error("miss word with non-zero payload");

   // an edge write starts the sequencer
   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == eri_pkg::REG_EDGE_START_X || csr_index == eri_pkg::REG_EDGE_START_Y ||
        csr_index == eri_pkg::REG_EDGE_END_X || csr_index == eri_pkg::REG_EDGE_END_Y))
      |=> status.busy)
      else $error("edge write did not start the normal sequencer");

endmodule

### src/eri_edge.sv
// Edge registers and the sequencer that derives the unit edge normal.
// Depends on eri_pkg; a bit-per-cycle root and two restoring dividers.
module eri_edge #(
   parameter int ROT_FRAC_BITS = eri_pkg::DEF_ROT_FRAC_BITS,
   localparam int NW = ROT_FRAC_BITS + 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [eri_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [eri_pkg::COORD_W-1:0]       csr_data,
   output logic signed [eri_pkg::COORD_W-1:0] edge_v1x,
   output logic signed [eri_pkg::COORD_W-1:0] edge_v1y,
   output logic signed [eri_pkg::COORD_W:0]   edge_ex,
   output logic signed [eri_pkg::COORD_W:0]   edge_ey,
   output logic signed [NW-1:0]              edge_nx,
   output logic signed [NW-1:0]              edge_ny,
   output eri_pkg::eri_status_type           status
);
   localparam int QD   = ROT_FRAC_BITS + 2;
   localparam int DVW  = ROT_FRAC_BITS + 33;
   localparam int CNTW = $clog2(eri_pkg::SQRT_STEPS);
   localparam int EW   = eri_pkg::COORD_W + 1;

   eri_pkg::eri_seq_type state_ff, state_in;

   logic signed [eri_pkg::COORD_W-1:0] v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [EW-1:0] ex_ff, ey_ff;
   logic [EW-1:0]        abs_a, abs_b;
   logic [30:0]          a_ff, b_ff, a_in, b_in;
   logic [62:0]          rv_ff, res_ff, bit_ff, rv_in, res_in;
   logic [63:0]          trial;
   logic [CNTW-1:0]      cnt_ff;
   logic [DVW-1:0]       rem_a_ff, rem_b_ff, dsh_ff;
   logic [QD-1:0]        qa_ff, qb_ff;
   logic [31:0]          len;
   logic                 csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid && (csr_index == eri_pkg::REG_EDGE_START_X ||
                                 csr_index == eri_pkg::REG_EDGE_START_Y ||
                                 csr_index == eri_pkg::REG_EDGE_END_X ||
                                 csr_index == eri_pkg::REG_EDGE_END_Y);

   // write the edge registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1x_ff <= '0;
         v1y_ff <= '0;
         v2x_ff <= '0;
         v2y_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            eri_pkg::REG_EDGE_START_X: v1x_ff <= csr_data;
            eri_pkg::REG_EDGE_START_Y: v1y_ff <= csr_data;
            eri_pkg::REG_EDGE_END_X:   v2x_ff <= csr_data;
            eri_pkg::REG_EDGE_END_Y:   v2y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next state: a write restarts the sequence
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eri_pkg::SEQ_IDLE:   state_in = eri_pkg::SEQ_IDLE;
         eri_pkg::SEQ_DIFF:   state_in = eri_pkg::SEQ_SCALE;
         eri_pkg::SEQ_SCALE:  state_in = eri_pkg::SEQ_SQUARE;
         eri_pkg::SEQ_SQUARE: state_in = eri_pkg::SEQ_ROOT;
         eri_pkg::SEQ_ROOT:
            if (cnt_ff == CNTW'(eri_pkg::SQRT_STEPS - 1)) state_in = eri_pkg::SEQ_DINIT;
         eri_pkg::SEQ_DINIT:  state_in = eri_pkg::SEQ_DIVIDE;
         eri_pkg::SEQ_DIVIDE:
            if (cnt_ff == CNTW'(QD - 1)) state_in = eri_pkg::SEQ_IDLE;
         default:             state_in = eri_pkg::SEQ_IDLE;
      endcase
      if (csr_wr) state_in = eri_pkg::SEQ_DIFF;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= eri_pkg::SEQ_IDLE;
      else       state_ff <= state_in;
   end

   // outputs of the sequencer
   always_comb begin
      status.busy      = (state_ff != eri_pkg::SEQ_IDLE);
      status.edge_zero = (ex_ff == '0) && (ey_ff == '0);
   end

   // magnitudes brought below 2^31 by at most two halvings
   always_comb begin
      abs_a = ey_ff[EW-1] ? EW'(-ey_ff) : EW'(ey_ff);
      abs_b = ex_ff[EW-1] ? EW'(-ex_ff) : EW'(ex_ff);
      if (abs_a[32] || abs_b[32]) begin
         a_in = abs_a[32:2];
         b_in = abs_b[32:2];
      end else if (abs_a[31] || abs_b[31]) begin
         a_in = abs_a[31:1];
         b_in = abs_b[31:1];
      end else begin
         a_in = abs_a[30:0];
         b_in = abs_b[30:0];
      end
   end

   // one root step
   always_comb begin
      trial = 64'(res_ff) + 64'(bit_ff);
      if (64'(rv_ff) >= trial) begin
         rv_in  = rv_ff - trial[62:0];
         res_in = (res_ff >> 1) + bit_ff;
      end else begin
         rv_in  = rv_ff;
         res_in = res_ff >> 1;
      end
   end

   assign len = res_ff[31:0];

   // edge datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_ff  <= '0;
         ey_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         case (state_ff)
            eri_pkg::SEQ_DIFF: begin
               ex_ff <= EW'(v2x_ff) - EW'(v1x_ff);
               ey_ff <= EW'(v2y_ff) - EW'(v1y_ff);
            end
            eri_pkg::SEQ_SCALE: begin
               a_ff <= a_in;
               b_ff <= b_in;
            end
            eri_pkg::SEQ_SQUARE: begin
               rv_ff  <= 63'(a_ff) * 63'(a_ff) + 63'(b_ff) * 63'(b_ff);
               res_ff <= '0;
               bit_ff <= 63'(1) << 62;
               cnt_ff <= '0;
            end
            eri_pkg::SEQ_ROOT: begin
               rv_ff  <= rv_in;
               res_ff <= res_in;
               bit_ff <= bit_ff >> 2;
               cnt_ff <= cnt_ff + 1'b1;
            end
            eri_pkg::SEQ_DINIT: begin
               rem_a_ff <= (DVW'(a_ff) << ROT_FRAC_BITS) + DVW'(len >> 1);
               rem_b_ff <= (DVW'(b_ff) << ROT_FRAC_BITS) + DVW'(len >> 1);
               dsh_ff   <= DVW'(len) << (QD - 1);
               cnt_ff   <= '0;
            end
            eri_pkg::SEQ_DIVIDE: begin
               if (rem_a_ff >= dsh_ff) begin
                  rem_a_ff <= rem_a_ff - dsh_ff;
                  qa_ff    <= {qa_ff[QD-2:0], 1'b1};
               end else begin
                  qa_ff    <= {qa_ff[QD-2:0], 1'b0};
               end
               if (rem_b_ff >= dsh_ff) begin
                  rem_b_ff <= rem_b_ff - dsh_ff;
                  qb_ff    <= {qb_ff[QD-2:0], 1'b1};
               end else begin
                  qb_ff    <= {qb_ff[QD-2:0], 1'b0};
               end
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // signed normal: (ey, -ex) direction
   assign edge_nx  = ey_ff[EW-1] ? -$signed({1'b0, qa_ff}) : $signed({1'b0, qa_ff});
   assign edge_ny  = (!ex_ff[EW-1] && ex_ff != '0) ? -$signed({1'b0, qb_ff})
                                                   : $signed({1'b0, qb_ff});
   assign edge_v1x = v1x_ff;
   assign edge_v1y = v1y_ff;
   assign edge_ex  = ex_ff;
   assign edge_ey  = ey_ff;

endmodule

### src/eri_front.sv
// Front pipeline: pose transform, products, miss tests and world normal.
// Depends on eri_pkg; edge terms come from eri_edge, results go to eri_div.
module eri_front #(
   parameter int COORD_FRAC_BITS = eri_pkg::DEF_COORD_FRAC_BITS,
   parameter int ROT_FRAC_BITS   = eri_pkg::DEF_ROT_FRAC_BITS,
   localparam int NW   = ROT_FRAC_BITS + 3,
   localparam int DW   = 51 - ROT_FRAC_BITS,
   localparam int NUMW = NW + DW + 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_take,
   output logic                               room,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_start_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_start_y,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_end_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_ray_end_y,
   input  logic [eri_pkg::FRAC_W-1:0]         req_max_fraction,
   input  logic signed [eri_pkg::COORD_W-1:0] req_pose_x,
   input  logic signed [eri_pkg::COORD_W-1:0] req_pose_y,
   input  logic signed [eri_pkg::ROT_W-1:0]   req_pose_cos,
   input  logic signed [eri_pkg::ROT_W-1:0]   req_pose_sin,
   input  logic signed [eri_pkg::COORD_W-1:0] edge_v1x,
   input  logic signed [eri_pkg::COORD_W-1:0] edge_v1y,
   input  logic signed [eri_pkg::COORD_W:0]   edge_ex,
   input  logic signed [eri_pkg::COORD_W:0]   edge_ey,
   input  logic signed [NW-1:0]               edge_nx,
   input  logic signed [NW-1:0]               edge_ny,
   input  logic                               edge_zero,
   output eri_pkg::eri_ctl_type               o_ctl,
   output logic [NUMW-1:0]                    o_unum,
   output logic [NUMW-1:0]                    o_uden,
   output logic signed [eri_pkg::ROT_W-1:0]   o_nx,
   output logic signed [eri_pkg::ROT_W-1:0]   o_ny,
   output logic [eri_pkg::FRAC_W-1:0]         o_maxf
);
   localparam int R    = ROT_FRAC_BITS;
   localparam int WW   = eri_pkg::COORD_W + 1;
   localparam int PRW  = WW + eri_pkg::ROT_W;
   localparam int SW   = PRW + 1;
   localparam int PW   = SW - R;
   localparam int LO   = DW / 2;
   localparam int HI   = DW - LO;
   localparam int XW   = 2 * DW + 1;
   localparam int NPW  = eri_pkg::ROT_W + NW;
   localparam int NSW  = NPW + 1;
   localparam int NRW  = NSW - R;
   localparam int CW   = NUMW + eri_pkg::FRAC_W;
   localparam logic signed [SW-1:0]  HALF_P = SW'(1) << (R - 1);
   localparam logic signed [NSW-1:0] HALF_N = NSW'(1) << (R - 1);
   localparam logic signed [NRW:0]   SAT_HI = (NRW+1)'(2 ** (eri_pkg::ROT_W - 1) - 1);
   localparam logic signed [NRW:0]   SAT_LO = -((NRW+1)'(2 ** (eri_pkg::ROT_W - 1)));

   // stage 1: world offsets from the pose
   logic v1_ff;
   logic signed [WW-1:0] dax_ff, day_ff, dbx_ff, dby_ff;
   logic signed [eri_pkg::ROT_W-1:0] c1_ff, s1_ff;
   logic [eri_pkg::FRAC_W-1:0] mf1_ff;
   logic load1;

   assign load1 = en || !v1_ff;
   assign room  = !v1_ff;

   always_ff @(posedge clock) begin
      if (reset)      v1_ff <= 1'b0;
      else if (load1) v1_ff <= in_take;
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         dax_ff <= WW'(req_ray_start_x) - WW'(req_pose_x);
         day_ff <= WW'(req_ray_start_y) - WW'(req_pose_y);
         dbx_ff <= WW'(req_ray_end_x) - WW'(req_pose_x);
         dby_ff <= WW'(req_ray_end_y) - WW'(req_pose_y);
         c1_ff  <= req_pose_cos;
         s1_ff  <= req_pose_sin;
         mf1_ff <= req_max_fraction;
      end
   end

   // stage 2: rotation products
   logic v2_ff;
   logic signed [PRW-1:0] cax_ff, say_ff, cay_ff, sax_ff;
   logic signed [PRW-1:0] cbx_ff, sby_ff, cby_ff, sbx_ff;
   logic signed [eri_pkg::ROT_W-1:0] c2_ff, s2_ff;
   logic [eri_pkg::FRAC_W-1:0] mf2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cax_ff <= PRW'(c1_ff) * PRW'(dax_ff);
         say_ff <= PRW'(s1_ff) * PRW'(day_ff);
         cay_ff <= PRW'(c1_ff) * PRW'(day_ff);
         sax_ff <= PRW'(s1_ff) * PRW'(dax_ff);
         cbx_ff <= PRW'(c1_ff) * PRW'(dbx_ff);
         sby_ff <= PRW'(s1_ff) * PRW'(dby_ff);
         cby_ff <= PRW'(c1_ff) * PRW'(dby_ff);
         sbx_ff <= PRW'(s1_ff) * PRW'(dbx_ff);
         c2_ff  <= c1_ff;
         s2_ff  <= s1_ff;
         mf2_ff <= mf1_ff;
      end
   end

   // stage 3: body-frame points, rounded half up
   logic v3_ff;
   logic signed [SW-1:0] sum_ax, sum_ay, sum_bx, sum_by;
   logic signed [PW-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [eri_pkg::ROT_W-1:0] c3_ff, s3_ff;
   logic [eri_pkg::FRAC_W-1:0] mf3_ff;

   always_comb begin
      sum_ax = SW'(cax_ff) + SW'(say_ff) + HALF_P;
      sum_ay = SW'(cay_ff) - SW'(sax_ff) + HALF_P;
      sum_bx = SW'(cbx_ff) + SW'(sby_ff) + HALF_P;
      sum_by = SW'(cby_ff) - SW'(sbx_ff) + HALF_P;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1x_ff <= sum_ax[SW-1:R];
         p1y_ff <= sum_ay[SW-1:R];
         p2x_ff <= sum_bx[SW-1:R];
         p2y_ff <= sum_by[SW-1:R];
         c3_ff  <= c2_ff;
         s3_ff  <= s2_ff;
         mf3_ff <= mf2_ff;
      end
   end

   // stage 4: ray direction and offset to the first vertex
   logic v4_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, qx_ff, qy_ff;
   logic signed [eri_pkg::ROT_W-1:0] c4_ff, s4_ff;
   logic [eri_pkg::FRAC_W-1:0] mf4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= DW'(p2x_ff) - DW'(p1x_ff);
         dy_ff  <= DW'(p2y_ff) - DW'(p1y_ff);
         qx_ff  <= DW'(edge_v1x) - DW'(p1x_ff);
         qy_ff  <= DW'(edge_v1y) - DW'(p1y_ff);
         c4_ff  <= c3_ff;
         s4_ff  <= s3_ff;
         mf4_ff <= mf3_ff;
      end
   end

   // stage 5: dot and cross partial products
   logic v5_ff;
   logic signed [HI-1:0] dxh, dyh;
   logic signed [LO:0]   dxl, dyl;
   logic signed [NUMW-1:0] nq1_ff, nq2_ff, nd1_ff, nd2_ff;
   logic signed [XW-1:0] xdxh_ff, xdxl_ff, xdyh_ff, xdyl_ff;
   logic signed [XW-1:0] ydyh_ff, ydyl_ff, ydxh_ff, ydxl_ff;
   logic signed [NPW-1:0] cnx_ff, sny_ff, snx_ff, cny_ff;
   logic [eri_pkg::FRAC_W-1:0] mf5_ff;

   always_comb begin
      dxh = $signed(dx_ff[DW-1:LO]);
      dyh = $signed(dy_ff[DW-1:LO]);
      dxl = $signed({1'b0, dx_ff[LO-1:0]});
      dyl = $signed({1'b0, dy_ff[LO-1:0]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nq1_ff  <= NUMW'(edge_nx) * NUMW'(qx_ff);
         nq2_ff  <= NUMW'(edge_ny) * NUMW'(qy_ff);
         nd1_ff  <= NUMW'(edge_nx) * NUMW'(dx_ff);
         nd2_ff  <= NUMW'(edge_ny) * NUMW'(dy_ff);
         xdxh_ff <= XW'(qy_ff) * XW'(dxh);
         xdxl_ff <= XW'(qy_ff) * XW'(dxl);
         xdyh_ff <= XW'(qx_ff) * XW'(dyh);
         xdyl_ff <= XW'(qx_ff) * XW'(dyl);
         ydyh_ff <= XW'(edge_ex) * XW'(dyh);
         ydyl_ff <= XW'(edge_ex) * XW'(dyl);
         ydxh_ff <= XW'(edge_ey) * XW'(dxh);
         ydxl_ff <= XW'(edge_ey) * XW'(dxl);
         cnx_ff  <= NPW'(c4_ff) * NPW'(edge_nx);
         sny_ff  <= NPW'(s4_ff) * NPW'(edge_ny);
         snx_ff  <= NPW'(s4_ff) * NPW'(edge_nx);
         cny_ff  <= NPW'(c4_ff) * NPW'(edge_ny);
         mf5_ff  <= mf4_ff;
      end
   end

   // stage 6: combine into num, den, cross terms and world normal
   logic v6_ff;
   logic signed [NUMW-1:0] num6_ff, den6_ff;
   logic signed [XW-1:0]   x6_ff, y6_ff;
   logic signed [NSW-1:0]  wsx, wsy;
   logic signed [NRW-1:0]  wx6_ff, wy6_ff;
   logic [eri_pkg::FRAC_W-1:0] mf6_ff;

   always_comb begin
      wsx = NSW'(cnx_ff) - NSW'(sny_ff) + HALF_N;
      wsy = NSW'(snx_ff) + NSW'(cny_ff) + HALF_N;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num6_ff <= nq1_ff + nq2_ff;
         den6_ff <= nd1_ff + nd2_ff;
         x6_ff   <= ((xdxh_ff - xdyh_ff) <<< LO) + xdxl_ff - xdyl_ff;
         y6_ff   <= ((ydyh_ff - ydxh_ff) <<< LO) + ydyl_ff - ydxl_ff;
         wx6_ff  <= wsx[NSW-1:R];
         wy6_ff  <= wsy[NSW-1:R];
         mf6_ff  <= mf5_ff;
      end
   end

   // stage 7: sign tests, magnitudes, normal flip toward the origin
   logic v7_ff, miss7_ff, numpos;
   logic signed [XW-1:0] xn7_ff, yn7_ff;
   logic [NUMW-1:0] unum7_ff, uden7_ff;
   logic signed [NRW:0] wx7_ff, wy7_ff;
   logic [eri_pkg::FRAC_W-1:0] mf7_ff;

   assign numpos = !num6_ff[NUMW-1] && (num6_ff != '0);

   always_ff @(posedge clock) begin
      if (en) begin
         miss7_ff <= (den6_ff == '0) || (y6_ff == '0) ||
                     ((num6_ff != '0) && (num6_ff[NUMW-1] != den6_ff[NUMW-1]));
         xn7_ff   <= y6_ff[XW-1] ? -x6_ff : x6_ff;
         yn7_ff   <= y6_ff[XW-1] ? -y6_ff : y6_ff;
         unum7_ff <= num6_ff[NUMW-1] ? NUMW'(-num6_ff) : NUMW'(num6_ff);
         uden7_ff <= den6_ff[NUMW-1] ? NUMW'(-den6_ff) : NUMW'(den6_ff);
         wx7_ff   <= numpos ? -((NRW+1)'(wx6_ff)) : (NRW+1)'(wx6_ff);
         wy7_ff   <= numpos ? -((NRW+1)'(wy6_ff)) : (NRW+1)'(wy6_ff);
         mf7_ff   <= mf6_ff;
      end
   end

   // stage 8: edge range, fraction overflow, saturation
   logic v8_ff, miss8_ff, ovf;
   logic [NUMW-1:0] unum8_ff, uden8_ff;
   logic signed [eri_pkg::ROT_W-1:0] nx8_ff, ny8_ff;
   logic [eri_pkg::FRAC_W-1:0] mf8_ff;

   assign ovf = CW'(unum7_ff) >= (CW'(uden7_ff) << (eri_pkg::FRAC_W - COORD_FRAC_BITS));

   always_ff @(posedge clock) begin
      if (en) begin
         miss8_ff <= miss7_ff || edge_zero || xn7_ff[XW-1] || (xn7_ff > yn7_ff) || ovf;
         unum8_ff <= unum7_ff;
         uden8_ff <= uden7_ff;
         nx8_ff   <= (wx7_ff > SAT_HI) ? eri_pkg::ROT_W'(SAT_HI) :
                     (wx7_ff < SAT_LO) ? eri_pkg::ROT_W'(SAT_LO) : eri_pkg::ROT_W'(wx7_ff);
         ny8_ff   <= (wy7_ff > SAT_HI) ? eri_pkg::ROT_W'(SAT_HI) :
                     (wy7_ff < SAT_LO) ? eri_pkg::ROT_W'(SAT_LO) : eri_pkg::ROT_W'(wy7_ff);
         mf8_ff   <= mf7_ff;
      end
   end

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
      end
   end

   assign o_ctl.valid = v8_ff;
   assign o_ctl.miss  = miss8_ff;
   assign o_unum      = unum8_ff;
   assign o_uden      = uden8_ff;
   assign o_nx        = nx8_ff;
   assign o_ny        = ny8_ff;
   assign o_maxf      = mf8_ff;

endmodule

### src/eri_div.sv
// Pipelined restoring divider for the hit fraction, one quotient bit a stage,
// followed by the range check and the result register. Depends on eri_pkg.
module eri_div #(
   parameter int COORD_FRAC_BITS = eri_pkg::DEF_COORD_FRAC_BITS,
   parameter int ROT_FRAC_BITS   = eri_pkg::DEF_ROT_FRAC_BITS,
   localparam int NUMW = (ROT_FRAC_BITS + 3) + (51 - ROT_FRAC_BITS) + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  eri_pkg::eri_ctl_type              i_ctl,
   input  logic [NUMW-1:0]                   i_unum,
   input  logic [NUMW-1:0]                   i_uden,
   input  logic signed [eri_pkg::ROT_W-1:0]  i_nx,
   input  logic signed [eri_pkg::ROT_W-1:0]  i_ny,
   input  logic [eri_pkg::FRAC_W-1:0]        i_maxf,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic [eri_pkg::FRAC_W-1:0]        rsp_hit_fraction,
   output logic signed [eri_pkg::ROT_W-1:0]  rsp_normal_x,
   output logic signed [eri_pkg::ROT_W-1:0]  rsp_normal_y
);
   localparam int T  = eri_pkg::FRAC_W;
   localparam int CW = NUMW + T;

   eri_pkg::eri_ctl_type ctl_ff [1:T];
   logic [CW-1:0]   rem_ff  [1:T];
   logic [NUMW-1:0] den_ff  [1:T];
   logic [T-1:0]    q_ff    [1:T];
   logic signed [eri_pkg::ROT_W-1:0] nx_ff [1:T];
   logic signed [eri_pkg::ROT_W-1:0] ny_ff [1:T];
   logic [T-1:0]    mf_ff   [1:T];

   eri_pkg::eri_ctl_type st_ctl [0:T-1];
   logic [CW-1:0]   st_rem [0:T-1];
   logic [NUMW-1:0] st_den [0:T-1];
   logic [T-1:0]    st_q   [0:T-1];
   logic signed [eri_pkg::ROT_W-1:0] st_nx [0:T-1];
   logic signed [eri_pkg::ROT_W-1:0] st_ny [0:T-1];
   logic [T-1:0]    st_mf  [0:T-1];

   // stage inputs: the front word, then the previous stage
   always_comb begin
      st_ctl[0] = i_ctl;
      st_rem[0] = CW'(i_unum) << COORD_FRAC_BITS;
      st_den[0] = i_uden;
      st_q[0]   = '0;
      st_nx[0]  = i_nx;
      st_ny[0]  = i_ny;
      st_mf[0]  = i_maxf;
      for (int j = 1; j < T; j++) begin
         st_ctl[j] = ctl_ff[j];
         st_rem[j] = rem_ff[j];
         st_den[j] = den_ff[j];
         st_q[j]   = q_ff[j];
         st_nx[j]  = nx_ff[j];
         st_ny[j]  = ny_ff[j];
         st_mf[j]  = mf_ff[j];
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar j = 0; j < T; j++) begin : g_stage
      logic [CW-1:0] trial;
      logic          take;

      assign trial = CW'(st_den[j]) << (T - 1 - j);
      assign take  = (st_rem[j] >= trial);

      always_ff @(posedge clock) begin
         if (reset)   ctl_ff[j+1].valid <= 1'b0;
         else if (en) ctl_ff[j+1].valid <= st_ctl[j].valid;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            ctl_ff[j+1].miss <= st_ctl[j].miss;
            rem_ff[j+1]      <= take ? st_rem[j] - trial : st_rem[j];
            den_ff[j+1]      <= st_den[j];
            q_ff[j+1]        <= {st_q[j][T-2:0], take};
            nx_ff[j+1]       <= st_nx[j];
            ny_ff[j+1]       <= st_ny[j];
            mf_ff[j+1]       <= st_mf[j];
         end
      end
   end

   // result word: zero everything on a miss
   logic hit;
   logic out_valid_ff;

   assign hit = !ctl_ff[T].miss && (q_ff[T] <= mf_ff[T]);

   always_ff @(posedge clock) begin
      if (reset)   out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= ctl_ff[T].valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit          <= hit;
         rsp_hit_fraction <= hit ? q_ff[T] : '0;
         rsp_normal_x     <= hit ? nx_ff[T] : '0;
         rsp_normal_y     <= hit ? ny_ff[T] : '0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule
